// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the tour length block.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/nnt_pkg.sv =====
// Package for the nearest neighbour tour length block: field widths, codes,
// sequencer states and the accumulator control group. Depends on nothing.
package nnt_pkg;
	localparam int NUM_W = 7;
	localparam int CITY_W = 6;
	localparam int EDGE_W = 32;
	localparam int LEN_W = 48;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [NUM_W-1:0] NUM_CITIES_RESET = 7'd64;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RUN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_CLOSE,
		ST_CLOSE_ADD,
		ST_FINISH
	} nnt_state_t;

	typedef struct packed {
		logic clear;
		logic add;
		logic publish;
	} acc_ctl_t;
endpackage

// ===== hdl/nnt_cost_store.sv =====
// Cost matrix memory: one write port for load items, one registered read port.
// Depends on nnt_pkg.
module nnt_cost_store #(
	parameter int MAX_CITIES = 64,
	parameter int COST_W = 32,
	parameter int ADDR_W = 12
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [nnt_pkg::CITY_W-1:0] wr_from,
	input  logic [nnt_pkg::CITY_W-1:0] wr_to,
	input  logic [nnt_pkg::EDGE_W-1:0] wr_cost,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [COST_W-1:0]          rd_data
);
	import nnt_pkg::*;

	localparam int DEPTH = MAX_CITIES * MAX_CITIES;

	logic [COST_W-1:0] mem [DEPTH];
	logic              in_range;
	logic [ADDR_W-1:0] wr_addr;

	// Writes outside the matrix are dropped.
	assign in_range = (32'(wr_from) < 32'(MAX_CITIES)) && (32'(wr_to) < 32'(MAX_CITIES));
	assign wr_addr = ADDR_W'(32'(wr_from) * 32'(MAX_CITIES) + 32'(wr_to));

	always_ff @(posedge clk) begin
		if (we && in_range) begin
			mem[wr_addr] <= wr_cost[COST_W-1:0];
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ===== hdl/nnt_cand_list.sv =====
// Candidate list memory holding the cities not yet visited.
// Depends on nothing.
module nnt_cand_list #(
	parameter int MAX_CITIES = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [IDX_W-1:0] wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [IDX_W-1:0] rdata
);
	logic [IDX_W-1:0] mem [MAX_CITIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/nnt_len_acc.sv =====
// Saturating tour length accumulator and the result output register.
// Depends on nnt_pkg.
module nnt_len_acc #(
	parameter int COST_W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nnt_pkg::acc_ctl_t         ctl,
	input  logic [COST_W-1:0]         add_val,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [nnt_pkg::LEN_W-1:0] tour_length,
	output logic                      saturated,
	output logic                      out_busy
);
	import nnt_pkg::*;

	logic [LEN_W-1:0] sum_q;
	logic             sat_q;
	logic [LEN_W:0]   sum_wide;
	logic             at_max;
	logic             sat_hit;

	assign sum_wide = {1'b0, sum_q} + (LEN_W + 1)'(add_val);
	assign at_max = sum_wide >= {1'b0, LEN_MAX};
	// Landing exactly on the maximum with a zero cost does not count as a hit.
	assign sat_hit = at_max && ((sum_wide > {1'b0, LEN_MAX}) || (add_val != '0));
	assign out_busy = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sat_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ctl.clear) begin
				sum_q <= '0;
				sat_q <= 1'b0;
			end else if (ctl.add) begin
				sum_q <= at_max ? LEN_MAX : sum_wide[LEN_W-1:0];
				sat_q <= sat_q || sat_hit;
			end
			if (ctl.publish) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			tour_length <= sum_q;
			saturated <= sat_q;
		end
	end
endmodule

// ===== hdl/nnt_ctrl.sv =====
// Sequencer for one tour run: candidate setup sweep, minimum scan through the
// shared cost read port and compare unit, list update and closing edge.
// Depends on nnt_pkg.
module nnt_ctrl #(
	parameter int MAX_CITIES = 64,
	parameter int IDX_W = 6,
	parameter int COST_W = 32,
	parameter int ADDR_W = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      op,
	input  logic [nnt_pkg::NUM_W-1:0] num_cities,
	input  logic                      out_busy,
	input  logic [IDX_W-1:0]          cand_rdata,
	input  logic [COST_W-1:0]         cost_rdata,
	output logic                      in_stall,
	output logic                      cand_we,
	output logic [IDX_W-1:0]          cand_waddr,
	output logic [IDX_W-1:0]          cand_wdata,
	output logic [IDX_W-1:0]          cand_raddr,
	output logic [ADDR_W-1:0]         cost_raddr,
	output nnt_pkg::acc_ctl_t         acc_ctl,
	output logic [COST_W-1:0]         add_val
);
	import nnt_pkg::*;

	localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

	nnt_state_t       state_q, state_next;
	logic             start;
	logic [31:0]      num_ext;
	logic [IDX_W-1:0] last_new;
	logic [IDX_W-1:0] last_idx_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] init_idx_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] prev_q;
	logic [IDX_W-1:0] city_sel;

	logic             valid_s1, first_s1, last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             valid_s2, first_s2, last_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [IDX_W-1:0] city_s2;

	logic [COST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_loc_q;
	logic [IDX_W-1:0]  best_city_q;
	logic [IDX_W-1:0]  last_city_q;

	assign in_stall = (state_q != ST_IDLE);
	assign start = in_valid && !in_stall && (op == OP_RUN);

	// Highest city index of the run; zero cities act as one.
	always_comb begin
		num_ext = 32'(num_cities);
		if (num_ext == 32'd0) begin
			last_new = '0;
		end else if (num_ext > 32'(MAX_CITIES)) begin
			last_new = IDX_W'(MAX_CITIES - 1);
		end else begin
			last_new = IDX_W'(num_ext - 32'd1);
		end
	end

	assign cand_raddr = scan_idx_q;
	assign city_sel = (state_q == ST_CLOSE) ? '0 : cand_rdata;
	assign cost_raddr = ADDR_W'(32'(prev_q) * 32'(MAX_CITIES) + 32'(city_sel));
	assign add_val = (state_q == ST_UPDATE) ? best_q : cost_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cand_we = 1'b0;
		cand_waddr = best_loc_q;
		cand_wdata = last_city_q;
		acc_ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					acc_ctl.clear = 1'b1;
					state_next = (last_new == '0) ? ST_CLOSE : ST_INIT;
				end
			end
			ST_INIT: begin
				// City 0 starts the tour, so its slot takes the last city.
				cand_we = 1'b1;
				cand_waddr = init_idx_q;
				cand_wdata = (init_idx_q == '0) ? last_idx_q : init_idx_q;
				if (init_idx_q == last_idx_q - ONE) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == rem_q - ONE) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (valid_s2 && last_s2) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// The chosen slot is refilled with the last remaining candidate.
				cand_we = 1'b1;
				acc_ctl.add = 1'b1;
				state_next = (rem_q == ONE) ? ST_CLOSE : ST_SCAN;
			end
			ST_CLOSE: begin
				state_next = ST_CLOSE_ADD;
			end
			ST_CLOSE_ADD: begin
				acc_ctl.add = 1'b1;
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_busy) begin
					acc_ctl.publish = 1'b1;
					state_next = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= '0;
			rem_q <= '0;
			init_idx_q <= '0;
			scan_idx_q <= '0;
			prev_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			valid_s2 <= valid_s1;
			if (start) begin
				last_idx_q <= last_new;
				rem_q <= last_new;
				init_idx_q <= '0;
				scan_idx_q <= '0;
				prev_q <= '0;
			end
			if (state_q == ST_INIT) begin
				init_idx_q <= init_idx_q + ONE;
			end
			if (state_q == ST_SCAN) begin
				scan_idx_q <= scan_idx_q + ONE;
			end
			if (state_q == ST_UPDATE) begin
				rem_q <= rem_q - ONE;
				prev_q <= best_city_q;
				scan_idx_q <= '0;
			end
		end
	end

	// Scan pipeline: list read, then cost read, then the compare.
	always_ff @(posedge clk) begin
		first_s1 <= (scan_idx_q == '0);
		last_s1 <= (scan_idx_q == rem_q - ONE);
		idx_s1 <= scan_idx_q;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		idx_s2 <= idx_s1;
		city_s2 <= cand_rdata;
		// Strict compare keeps the earliest list position on a tie.
		if (valid_s2 && (first_s2 || (cost_rdata < best_q))) begin
			best_q <= cost_rdata;
			best_loc_q <= idx_s2;
			best_city_q <= city_s2;
		end
		if (valid_s2 && last_s2) begin
			last_city_q <= city_s2;
		end
	end
endmodule

// ===== hdl/nearest_neighbour_tour_length.sv =====
// Top level of the greedy nearest neighbour tour length block.
// Depends on nnt_pkg, nnt_cost_store, nnt_cand_list, nnt_len_acc, nnt_ctrl and assert_macros.svh.
//
//   channel  handshake            payload
//   cfg      cfg_valid/cfg_ready  cfg_data (num_cities)
//   in       in_valid/in_stall    op, from_city, to_city, edge_cost
//   out      out_valid/out_stall  tour_length, saturated
//
// A write item leaves the block free for the next item. A run item holds
// in_stall high until its result is published; each scan walks the single
// cost read port one entry per cycle.
// Reset sets num_cities to 64; the cost matrix is undefined until written.
// A stalled result holds the block at the end of the next run only.
`include "assert_macros.svh"

module nearest_neighbour_tour_length #(
	parameter int MAX_CITIES = 64,
	parameter int COST_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [nnt_pkg::NUM_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [nnt_pkg::CITY_W-1:0] from_city,
	input  logic [nnt_pkg::CITY_W-1:0] to_city,
	input  logic [nnt_pkg::EDGE_W-1:0] edge_cost,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [nnt_pkg::LEN_W-1:0]  tour_length,
	output logic                       saturated
);
	import nnt_pkg::*;

	localparam int IDX_W = $clog2(MAX_CITIES);
	localparam int COST_W = (COST_BITS < EDGE_W) ? COST_BITS : EDGE_W;
	localparam int ADDR_W = $clog2(MAX_CITIES * MAX_CITIES);

	logic [NUM_W-1:0]  num_cities_q;
	logic              cost_we;
	logic [ADDR_W-1:0] cost_raddr;
	logic [COST_W-1:0] cost_rdata;
	logic              cand_we;
	logic [IDX_W-1:0]  cand_waddr;
	logic [IDX_W-1:0]  cand_wdata;
	logic [IDX_W-1:0]  cand_raddr;
	logic [IDX_W-1:0]  cand_rdata;
	acc_ctl_t          acc_ctl;
	logic [COST_W-1:0] add_val;
	logic              out_busy;

	assign cfg_ready = 1'b1;
	assign cost_we = in_valid && !in_stall && (op == OP_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cities_q <= NUM_CITIES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_cities_q <= cfg_data;
		end
	end

	nnt_cost_store #(
		.MAX_CITIES(MAX_CITIES),
		.COST_W(COST_W),
		.ADDR_W(ADDR_W)
	) u_cost_store (
		.clk(clk),
		.we(cost_we),
		.wr_from(from_city),
		.wr_to(to_city),
		.wr_cost(edge_cost),
		.rd_addr(cost_raddr),
		.rd_data(cost_rdata)
	);

	nnt_cand_list #(
		.MAX_CITIES(MAX_CITIES),
		.IDX_W(IDX_W)
	) u_cand_list (
		.clk(clk),
		.we(cand_we),
		.waddr(cand_waddr),
		.wdata(cand_wdata),
		.raddr(cand_raddr),
		.rdata(cand_rdata)
	);

	nnt_len_acc #(
		.COST_W(COST_W)
	) u_len_acc (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(acc_ctl),
		.add_val(add_val),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.tour_length(tour_length),
		.saturated(saturated),
		.out_busy(out_busy)
	);

	nnt_ctrl #(
		.MAX_CITIES(MAX_CITIES),
		.IDX_W(IDX_W),
		.COST_W(COST_W),
		.ADDR_W(ADDR_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.op(op),
		.num_cities(num_cities_q),
		.out_busy(out_busy),
		.cand_rdata(cand_rdata),
		.cost_rdata(cost_rdata),
		.in_stall(in_stall),
		.cand_we(cand_we),
		.cand_waddr(cand_waddr),
		.cand_wdata(cand_wdata),
		.cand_raddr(cand_raddr),
		.cost_raddr(cost_raddr),
		.acc_ctl(acc_ctl),
		.add_val(add_val)
	);

	// A run occupies the block; a write leaves it free for the next item.
	`ASSERT_NEXT(a_run_holds_input, clk, arst_n, in_valid && !in_stall && op == OP_RUN, in_stall)
	`ASSERT_NEXT(a_write_keeps_ready, clk, arst_n, in_valid && !in_stall && op == OP_WRITE, !in_stall)
	// A new result only appears at the end of a run.
	`ASSERT_IMPLIES(a_result_from_run, clk, arst_n, $rose(out_valid), $past(in_stall))
	// A saturated sum is clamped at the top of its range.
	`ASSERT_IMPLIES(a_sat_clamped, clk, arst_n, out_valid && saturated, tour_length == LEN_MAX)
endmodule

// ===== verif/tour_length_checker.sv =====
// Checker for the nearest neighbour tour length block: it watches the config,
// input and result channels, predicts each tour length and compares.
// Depends on nnt_pkg for field widths, the op codes and the reset city count.
module tour_length_checker #(
	parameter int MAX_CITIES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [nnt_pkg::NUM_W-1:0]   cfg_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        op,
	input  logic [nnt_pkg::CITY_W-1:0]  from_city,
	input  logic [nnt_pkg::CITY_W-1:0]  to_city,
	input  logic [nnt_pkg::EDGE_W-1:0]  edge_cost,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [nnt_pkg::LEN_W-1:0]   tour_length,
	input  logic                        saturated,
	output int                          mismatches,
	output int                          tours_pending
);
	import nnt_pkg::*;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             sat;
	} tour_t;

	logic [EDGE_W-1:0] cost_matrix [MAX_CITIES][MAX_CITIES];
	logic [NUM_W-1:0]  city_count;
	tour_t             expected_tours [$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Greedy tour from city 0. The candidate list loses city 0 by moving its
	// last entry into slot 0, and every chosen slot is refilled the same way.
	// The last pass of the loop adds the edge back to city 0.
	function automatic tour_t greedy_tour(input logic [NUM_W-1:0] cities);
		int n;
		int left;
		int pick;
		logic [CITY_W-1:0] cand [MAX_CITIES];
		logic [CITY_W-1:0] at;
		logic [EDGE_W-1:0] leg;
		logic [LEN_W:0]    sum;
		tour_t             t;
		n = cities;
		if (n == 0)
			n = 1;
		if (n > MAX_CITIES)
			n = MAX_CITIES;
		for (int i = 0; i < n; i++)
			cand[i] = i[CITY_W-1:0];
		cand[0] = cand[n-1];
		left = n - 1;
		at = '0;
		sum = '0;
		t.sat = 1'b0;
		for (int step = 0; step < n; step++) begin
			pick = 0;
			if (left > 0) begin
				leg = cost_matrix[at][cand[0]];
				for (int m = 1; m < left; m++) begin
					if (cost_matrix[at][cand[m]] < leg) begin
						leg = cost_matrix[at][cand[m]];
						pick = m;
					end
				end
			end else begin
				leg = cost_matrix[at][0];
			end
			sum = sum + leg;
			if (sum >= {1'b0, LEN_MAX}) begin
				if (sum > {1'b0, LEN_MAX} || leg != '0)
					t.sat = 1'b1;
				sum = {1'b0, LEN_MAX};
			end
			if (left > 0) begin
				at = cand[pick];
				cand[pick] = cand[left-1];
				left--;
			end
		end
		t.len = sum[LEN_W-1:0];
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tour_t want;
		if (!arst_n) begin
			city_count = NUM_CITIES_RESET;
			expected_tours.delete();
			mismatches = 0;
			tours_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				city_count = cfg_data;
			if (in_valid && !in_stall) begin
				if (op == OP_WRITE)
					cost_matrix[from_city][to_city] = edge_cost;
				else
					expected_tours = {expected_tours, greedy_tour(city_count)};
			end
			if (out_valid && !out_stall) begin
				if (expected_tours.size() == 0) begin
					report_mismatch("tour_length with no run waiting", 64'(tour_length),
						64'(0));
				end else begin
					want = expected_tours.pop_front();
					if (tour_length !== want.len)
						report_mismatch("tour_length", 64'(tour_length), 64'(want.len));
					if (saturated !== want.sat)
						report_mismatch("saturated", 64'(saturated), 64'(want.sat));
				end
			end
			// Registered so that the stimulus side reads it without a race.
			tours_pending <= expected_tours.size();
		end
	end
endmodule

// ===== verif/nearest_neighbour_tour_length_test.sv =====
// Top of the nearest neighbour tour length testbench: clock, reset, stimulus
// and verdict. Depends on nnt_pkg, the block and tour_length_checker.
module nearest_neighbour_tour_length_test;
	import nnt_pkg::*;

	localparam int NUM_PHASES = 10;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [NUM_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                op = OP_WRITE;
	logic [CITY_W-1:0]   from_city = '0;
	logic [CITY_W-1:0]   to_city = '0;
	logic [EDGE_W-1:0]   edge_cost = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [LEN_W-1:0]    tour_length;
	logic                saturated;
	int                  mismatches;
	int                  tours_pending;

	int idle_pct = 0;
	int stall_pct = 0;

	// Per phase: city count register value, sender idle and receiver stall
	// percentages, and how many items to send.
	int phase_cities [NUM_PHASES] = '{5, 3, 8, 2, 127, 64, 1, 16, 0, 11};
	int phase_idle [NUM_PHASES] = '{0, 61, 0, 23, 61, 0, 23, 0, 0, 61};
	int phase_stall [NUM_PHASES] = '{0, 0, 61, 23, 0, 61, 23, 0, 61, 0};
	int phase_items [NUM_PHASES] = '{250, 250, 250, 250, 25, 25, 150, 200, 100, 150};

	nearest_neighbour_tour_length dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.from_city(from_city),
		.to_city(to_city),
		.edge_cost(edge_cost),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tour_length(tour_length),
		.saturated(saturated)
	);

	tour_length_checker tour_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.from_city(from_city),
		.to_city(to_city),
		.edge_cost(edge_cost),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tour_length(tour_length),
		.saturated(saturated),
		.mismatches(mismatches),
		.tours_pending(tours_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Zero, all ones, small values that tie often, near the top, or anything.
	function automatic logic [EDGE_W-1:0] random_cost();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return EDGE_W'($urandom_range(3));
			3: return '1 - EDGE_W'($urandom_range(3));
			default: return EDGE_W'($urandom());
		endcase
	endfunction

	task automatic send_item(input logic kind, input logic [CITY_W-1:0] f,
			input logic [CITY_W-1:0] t, input logic [EDGE_W-1:0] c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		from_city <= f;
		to_city <= t;
		edge_cost <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic write_cost(input int f, input int t, input logic [EDGE_W-1:0] c);
		send_item(OP_WRITE, CITY_W'(f), CITY_W'(t), c);
	endtask

	// The unused fields of a run item carry random values.
	task automatic run_tour();
		send_item(OP_RUN, CITY_W'($urandom()), CITY_W'($urandom()), EDGE_W'($urandom()));
	endtask

	task automatic drain_tours();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tours_pending != 0)
			@(posedge clk);
	endtask

	// Only written with the block idle; a cost write may still be in flight
	// after the last result, so a few cycles pass first.
	task automatic set_cities(input int value);
		drain_tours();
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= NUM_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int n;
		int sent;
		int pick;
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry is written before any run, so no run reads an unset cost.
		for (int f = 0; f < 64; f++)
			for (int t = 0; t < 64; t++)
				write_cost(f, t, random_cost());
		run_tour();

		set_cities(1);
		run_tour();
		set_cities(0);
		run_tour();
		set_cities(127);
		run_tour();
		set_cities(3);
		for (int f = 0; f < 3; f++)
			for (int t = 0; t < 3; t++)
				write_cost(f, t, '1);
		run_tour();
		// After city 0 leaves, the list is 2, 1: the tie must pick city 2.
		write_cost(0, 1, 5);
		write_cost(0, 2, 5);
		write_cost(2, 1, 0);
		write_cost(1, 0, 9);
		run_tour();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_cities(phase_cities[p]);
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			n = phase_cities[p];
			if (n == 0)
				n = 1;
			if (n > 64)
				n = 64;
			sent = 0;
			while (sent < phase_items[p]) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					k = $urandom_range(1, 6);
					repeat (k) write_cost($urandom_range(n - 1), $urandom_range(n - 1),
						random_cost());
					run_tour();
					sent += k + 1;
				end else if (pick < 92) begin
					write_cost($urandom_range(63), $urandom_range(63), random_cost());
					sent++;
				end else if (pick < 98) begin
					run_tour();
					sent++;
				end else begin
					drain_tours();
				end
			end
		end

		drain_tours();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && tours_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/nnt_pkg.sv
hdl/nnt_cost_store.sv
hdl/nnt_cand_list.sv
hdl/nnt_len_acc.sv
hdl/nnt_ctrl.sv
hdl/nearest_neighbour_tour_length.sv
verif/tour_length_checker.sv
verif/nearest_neighbour_tour_length_test.sv
